// ===== sv/u8u16_pkg.sv =====
`timescale 1ns / 1ps
package u8u16_pkg;

  localparam int unsigned PendDepth = 3;
  localparam int unsigned ResBytes  = 6;
  localparam int unsigned CfgAddrW  = 3;

  // register index, taken from paddr[2]
  localparam logic CfgIdxBigEndian = 1'b0;

  localparam logic [15:0] Bom      = 16'hFEFF;
  localparam logic [15:0] SurrHi   = 16'hD800;
  localparam logic [15:0] SurrLo   = 16'hDC00;
  localparam logic [20:0] SuppBase = 21'h10000;

  typedef logic [PendDepth-1:0][7:0] pend_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [2:0] seq_len;
    logic       at_start;
  } ctl_t;

  typedef struct packed {
    logic       we;
    logic [1:0] idx;
  } pend_wr_t;

  typedef struct packed {
    logic [ResBytes-1:0][7:0] bytes;
    logic [2:0]               count;
  } res_t;

endpackage

// ===== sv/u8u16_core.sv =====
`timescale 1ns / 1ps
module u8u16_core (
  input  logic [7:0]         data_byte_i,
  input  logic               last_i,
  input  logic               big_endian_i,
  input  u8u16_pkg::ctl_t    ctl_i,
  input  u8u16_pkg::pend_t   pend_i,
  output u8u16_pkg::ctl_t    ctl_o,
  output u8u16_pkg::pend_wr_t pend_wr_o,
  output u8u16_pkg::res_t    res_o
);
  import u8u16_pkg::*;

  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    priority if (c < 8'h80) len = 3'd1;
    else if (c < 8'hC0)     len = 3'd0;
    else if (c < 8'hE0)     len = 3'd2;
    else if (c < 8'hF0)     len = 3'd3;
    else if (c < 8'hF8)     len = 3'd4;
    else                    len = 3'd0;
    return len;
  endfunction

  function automatic logic [20:0] decode(input logic [3:0][7:0] s, input logic [2:0] len);
    logic [20:0] cp;
    unique case (len)
      3'd1:    cp = {13'd0, s[0]};
      3'd2:    cp = {10'd0, s[0][4:0], s[1][5:0]};
      3'd3:    cp = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
      default: cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
    endcase
    return cp;
  endfunction

  logic [3:0][7:0] seq;
  logic [2:0]      byte_len;
  logic            complete;
  logic [20:0]     cp;
  logic [20:0]     cp_off;
  logic [7:0]      r0;
  logic [7:0]      r1;
  logic [2:0]      r0_len;
  logic [2:0]      r1_len;
  logic            two;
  logic [1:0][15:0] cu;
  logic [1:0]      cu_n;
  logic [2:0][15:0] units;
  logic [1:0]      n_units;

  always_comb begin
    seq[0] = (ctl_i.cnt == 2'd0) ? data_byte_i : pend_i[0];
    seq[1] = (ctl_i.cnt == 2'd1) ? data_byte_i : ((ctl_i.cnt > 2'd1) ? pend_i[1] : 8'h00);
    seq[2] = (ctl_i.cnt == 2'd2) ? data_byte_i : ((ctl_i.cnt > 2'd2) ? pend_i[2] : 8'h00);
    seq[3] = (ctl_i.cnt == 2'd3) ? data_byte_i : 8'h00;

    byte_len = lead_len(data_byte_i);
    complete = ({1'b0, ctl_i.cnt} + 3'd1) >= ctl_i.seq_len;
    cp       = decode(seq, ctl_i.seq_len);
    cp_off   = cp - SuppBase;

    // rescan after a dropped lead: at most two bytes
    r0     = seq[1];
    r1     = seq[2];
    r0_len = lead_len(r0);
    r1_len = lead_len(r1);
    two    = (ctl_i.cnt == 2'd2);

    cu   = '0;
    cu_n = 2'd0;
    if (ctl_i.cnt == 2'd0) begin
      if (byte_len == 3'd1) begin
        cu[0] = {8'h00, data_byte_i};
        cu_n  = 2'd1;
      end
    end else if (complete) begin
      if (cp[20:16] != 5'd0) begin
        cu[0] = SurrHi | {5'd0, cp_off[20:10]};
        cu[1] = SurrLo | {6'd0, cp_off[9:0]};
        cu_n  = 2'd2;
      end else begin
        cu[0] = cp[15:0];
        cu_n  = 2'd1;
      end
    end else if (last_i) begin
      priority if (r0_len == 3'd1) begin
        cu[0] = {8'h00, r0};
        cu_n  = 2'd1;
        if (two && r1_len == 3'd1) begin
          cu[1] = {8'h00, r1};
          cu_n  = 2'd2;
        end
      end else if (two && r0_len == 3'd2) begin
        cu[0] = {5'd0, r0[4:0], r1[5:0]};
        cu_n  = 2'd1;
      end else if (two && r1_len == 3'd1) begin
        cu[0] = {8'h00, r1};
        cu_n  = 2'd1;
      end else begin
        cu_n = 2'd0;
      end
    end

    // bom rides as the first unit; it only comes with an empty hold
    if (ctl_i.at_start) begin
      units   = {cu[1], cu[0], Bom};
      n_units = cu_n + 2'd1;
    end else begin
      units   = {16'h0000, cu[1], cu[0]};
      n_units = cu_n;
    end

    for (int k = 0; k < 3; k++) begin
      res_o.bytes[2*k]   = big_endian_i ? units[k][15:8] : units[k][7:0];
      res_o.bytes[2*k+1] = big_endian_i ? units[k][7:0]  : units[k][15:8];
    end
    res_o.count = {n_units, 1'b0};

    ctl_o          = ctl_i;
    ctl_o.at_start = 1'b0;
    pend_wr_o.we   = 1'b0;
    pend_wr_o.idx  = ctl_i.cnt;
    if (last_i) begin
      ctl_o.cnt      = 2'd0;
      ctl_o.seq_len  = 3'd0;
      ctl_o.at_start = 1'b1;
    end else if (ctl_i.cnt == 2'd0) begin
      if (byte_len > 3'd1) begin
        pend_wr_o.we  = 1'b1;
        ctl_o.cnt     = 2'd1;
        ctl_o.seq_len = byte_len;
      end
    end else if (complete) begin
      ctl_o.cnt     = 2'd0;
      ctl_o.seq_len = 3'd0;
    end else begin
      pend_wr_o.we = 1'b1;
      ctl_o.cnt    = ctl_i.cnt + 2'd1;
    end
  end

endmodule

// ===== sv/utf8_to_utf16_transcoder.sv =====
`timescale 1ns / 1ps
// channel  direction  handshake                   payload
// in       input      in_valid_i / in_stall_o     data_byte_i, last_of_buffer_i
// out      output     out_valid_o / out_stall_i   out_byte_o, last_of_run_o
// cfg      input      apb write/read, pready = 1  big_endian_order at address 0
//
// an accepted word waits in the input register until the result register frees, then is decoded in one pass
// into the result register, which drains one byte per cycle on the out channel while out_stall_i is low.
// an input word yields its bytes on the out channel: two for ascii, up to six.
// the one-byte output port draining the result register sets the pace of the input.
// reset empties both registers and arms the byte-order mark for the next buffer.
// out_stall_i holds the result register; the input register waits behind it.
module utf8_to_utf16_transcoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           last_of_buffer_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_byte_o,
  output logic                           last_of_run_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [u8u16_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import u8u16_pkg::*;

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // decoder state
  ctl_t       ctl_q, ctl_d;
  pend_t      pend_q;
  pend_wr_t   pend_wr;
  logic       big_endian_q;

  // result register, shifted toward entry zero as bytes leave
  logic [ResBytes-1:0][7:0] res_bytes_q;
  logic [2:0]               res_rem_q;
  res_t                     res;

  logic in_accept;
  logic out_accept;
  logic advance;
  logic cfg_write;

  u8u16_core u_core (
    .data_byte_i  (in_byte_q),
    .last_i       (in_last_q),
    .big_endian_i (big_endian_q),
    .ctl_i        (ctl_q),
    .pend_i       (pend_q),
    .ctl_o        (ctl_d),
    .pend_wr_o    (pend_wr),
    .res_o        (res)
  );

  assign out_valid_o   = (res_rem_q != 3'd0);
  assign out_byte_o    = res_bytes_q[0];
  assign last_of_run_o = (res_rem_q == 3'd1);
  assign out_accept    = out_valid_o && !out_stall_i;

  // the decoded word moves on once the result register is empty or empties now
  assign advance    = in_valid_q && (!out_valid_o || (last_of_run_o && out_accept));
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept || (in_valid_q && !advance);

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == CfgIdxBigEndian);
  assign prdata    = (paddr[2] == CfgIdxBigEndian) ? {31'd0, big_endian_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      ctl_q        <= '{cnt: 2'd0, seq_len: 3'd0, at_start: 1'b1};
      big_endian_q <= 1'b0;
      res_rem_q    <= 3'd0;
    end else begin
      in_valid_q <= in_valid_d;
      if (advance) begin
        ctl_q     <= ctl_d;
        res_rem_q <= res.count;
      end else if (out_accept) begin
        res_rem_q <= res_rem_q - 3'd1;
      end
      if (cfg_write) begin
        big_endian_q <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_of_buffer_i;
    end
    if (advance && pend_wr.we) begin
      pend_q[pend_wr.idx] <= in_byte_q;
    end
    if (advance) begin
      res_bytes_q <= res.bytes;
    end else if (out_accept) begin
      res_bytes_q <= {8'h00, res_bytes_q[ResBytes-1:1]};
    end
  end

endmodule

// ===== sv/u8u16_checker.sv =====
`timescale 1ns / 1ps
module u8u16_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [7:0]                     data_byte_i,
  input logic                           last_of_buffer_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [7:0]                     out_byte_o,
  input logic                           last_of_run_o,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [u8u16_pkg::CfgAddrW-1:0] paddr,
  input logic [31:0]                    pwdata,
  input logic [31:0]                    prdata,
  input logic                           pready
);
  import u8u16_pkg::*;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_byte_o) && $stable(last_of_run_o))
    else $error("stalled output word changed");

  // offered input word waits unchanged while stalled
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable(data_byte_i) && $stable(last_of_buffer_i))
    else $error("stalled input word changed");

  // a run drains without gaps
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)
    else $error("gap inside a result run");

  // input only waits behind a busy output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with output empty");

  // register reads back what was written
  a_cfg_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[2] == CfgIdxBigEndian) ##1
      (psel && !pwrite && paddr[2] == CfgIdxBigEndian) |->
        prdata[0] == $past(pwdata[0]))
    else $error("config readback mismatch");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_u8u16_checker (.*);

// ===== test/tb_utf8_to_utf16_transcoder.sv =====
`timescale 1ns / 1ps
module tb_utf8_to_utf16_transcoder;
  import u8u16_pkg::*;

  localparam time         HalfPeriod = 6ns;
  localparam int unsigned HoldCycles = 150;  // long receiver hold-off, fills the block
  localparam int unsigned DirRows    = 25;

  // apb addresses: the byte-order register and one index with no register behind it
  localparam logic [CfgAddrW-1:0] AddrBigEndian = {CfgIdxBigEndian, 2'b00};
  localparam logic [CfgAddrW-1:0] AddrUnused    = {~CfgIdxBigEndian, 2'b00};
  localparam logic                ApbWrite      = 1'b1;
  localparam logic                ApbRead       = 1'b0;

  typedef enum logic [1:0] {
    StallNone,
    StallHalf,
    StallEveryThird,
    StallSparse
  } stall_mode_e;

  // one utf-16 output byte and its end-of-run flag
  typedef struct packed {
    logic [7:0] ub;
    logic       lr;
  } utf16_byte_t;

  // directed row: input word, and optionally the output typed in by hand
  // (typed bytes sit first-out in the top byte of e)
  typedef struct packed {
    logic [7:0]       b;
    logic             last;
    logic             typed;
    logic [2:0]       n;
    logic [5:0][7:0]  e;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          data_byte_i;
  logic                last_of_buffer_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [7:0]          out_byte_o;
  logic                last_of_run_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  utf8_to_utf16_transcoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .last_of_buffer_i(last_of_buffer_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .last_of_run_o   (last_of_run_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // transcoder shadow state, kept in step with every accepted word
  logic                big_endian_cfg;
  logic [7:0]          held [0:2];
  logic [1:0]          held_cnt;
  logic [2:0]          held_len;
  logic                buf_start;

  logic [7:0]          utf16_now [$];  // bytes the current word produces
  utf16_byte_t         utf16_due [$];  // bytes still owed by the block

  // what the sender currently offers, seen by the scoreboard at acceptance
  logic                offer_typed;
  logic [2:0]          offer_n;
  logic [47:0]         offer_e;

  int unsigned         words_sent;
  int unsigned         bytes_out;
  int unsigned         backpressure_cycles;
  int unsigned         mismatches;
  int unsigned         burst_left;
  logic                hold_req;
  logic                hold_done;

  // directed words: ascii extremes, strays, every lead length, a supplementary
  // pair at the top of the range, an overlong form and a three-byte sequence whose
  // last byte ends its buffer, then a fresh buffer to bring the mark back
  stim_row_t stim_tab [DirRows] = '{
    {8'h41, 1'b0, 1'b1, 3'd4, 48'hFF_FE_41_00_00_00},  // mark then 'A'
    {8'h00, 1'b0, 1'b1, 3'd2, 48'h00_00_00_00_00_00},
    {8'h7F, 1'b0, 1'b1, 3'd2, 48'h7F_00_00_00_00_00},
    {8'h80, 1'b0, 1'b1, 3'd0, 48'h0},                  // stray continuation
    {8'hF8, 1'b0, 1'b1, 3'd0, 48'h0},                  // never a lead
    {8'hFF, 1'b0, 1'b1, 3'd0, 48'h0},
    {8'hC3, 1'b0, 1'b1, 3'd0, 48'h0},                  // lead held, nothing yet
    {8'hA9, 1'b0, 1'b0, 3'd0, 48'h0},
    {8'hE2, 1'b0, 1'b1, 3'd0, 48'h0},
    {8'h82, 1'b0, 1'b1, 3'd0, 48'h0},
    {8'hAC, 1'b0, 1'b0, 3'd0, 48'h0},
    {8'hF0, 1'b0, 1'b0, 3'd0, 48'h0},
    {8'h9F, 1'b0, 1'b0, 3'd0, 48'h0},
    {8'h98, 1'b0, 1'b0, 3'd0, 48'h0},
    {8'h80, 1'b0, 1'b0, 3'd0, 48'h0},
    {8'hF7, 1'b0, 1'b0, 3'd0, 48'h0},                  // largest 4-byte value
    {8'hBF, 1'b0, 1'b0, 3'd0, 48'h0},
    {8'hBF, 1'b0, 1'b0, 3'd0, 48'h0},
    {8'hBF, 1'b0, 1'b0, 3'd0, 48'h0},
    {8'hC0, 1'b0, 1'b0, 3'd0, 48'h0},                  // overlong nul
    {8'h80, 1'b0, 1'b0, 3'd0, 48'h0},
    {8'hE2, 1'b0, 1'b0, 3'd0, 48'h0},                  // buffer ends on the third byte
    {8'h82, 1'b0, 1'b0, 3'd0, 48'h0},
    {8'h41, 1'b1, 1'b0, 3'd0, 48'h0},
    {8'h42, 1'b1, 1'b1, 3'd4, 48'hFF_FE_42_00_00_00}   // new buffer, mark again
  };

  // ---------------------------------------------------------------------------
  // shadow transcoder
  // ---------------------------------------------------------------------------

  function automatic int unsigned lead_bytes(logic [7:0] c);
    if (c < 8'h80) return 1;
    if (c < 8'hC0) return 0;
    if (c < 8'hE0) return 2;
    if (c < 8'hF0) return 3;
    if (c < 8'hF8) return 4;
    return 0;
  endfunction

  // only the low six bits of a continuation count, they are never checked
  function automatic logic [20:0] decode_seq(logic [7:0] b0, logic [7:0] b1,
                                             logic [7:0] b2, logic [7:0] b3,
                                             int unsigned len);
    case (len)
      1: return {13'd0, b0};
      2: return {10'd0, b0[4:0], b1[5:0]};
      3: return {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      default: return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endcase
  endfunction

  // one 16-bit unit in the configured byte order, six bytes per word at most
  function automatic void emit_unit(logic [15:0] u);
    if (utf16_now.size() < ResBytes) utf16_now.push_back(big_endian_cfg ? u[15:8] : u[7:0]);
    if (utf16_now.size() < ResBytes) utf16_now.push_back(big_endian_cfg ? u[7:0] : u[15:8]);
  endfunction

  // supplementary code points split into a surrogate pair, low 16 bits each
  function automatic void emit_code_point(logic [20:0] cp);
    logic [20:0] v;
    if (cp < SuppBase) begin
      emit_unit(cp[15:0]);
    end else begin
      v = cp - SuppBase;
      emit_unit(SurrHi | {5'd0, v[20:10]});
      emit_unit(SurrLo | {6'd0, v[9:0]});
    end
  endfunction

  function automatic void transcode_word(logic [7:0] b, logic last);
    logic [7:0]  seq [0:6];
    int unsigned cnt;
    int unsigned i;
    int unsigned len;
    utf16_now.delete();
    if (buf_start) begin
      emit_unit(Bom);
      buf_start = 1'b0;
    end
    cnt = held_cnt;
    for (i = 0; i < 7; i++) seq[i] = 8'h00;
    for (i = 0; i < cnt; i++) seq[i] = held[i];
    seq[cnt] = b;
    if (last) begin
      // buffer end: a short sequence loses its lead, the rest is rescanned as leads
      i = 0;
      while (i < cnt + 1) begin
        len = lead_bytes(seq[i]);
        if (len == 0 || i + len > cnt + 1) begin
          i++;
        end else begin
          emit_code_point(decode_seq(seq[i], seq[i+1], seq[i+2], seq[i+3], len));
          i += len;
        end
      end
      held_cnt  = 2'd0;
      held_len  = 3'd0;
      buf_start = 1'b1;
    end else if (cnt == 0) begin
      len = lead_bytes(b);
      if (len == 1) begin
        emit_code_point({13'd0, b});
      end else if (len > 1) begin
        held[0]  = b;
        held_cnt = 2'd1;
        held_len = 3'(len);
      end
    end else if (cnt + 1 >= held_len) begin
      emit_code_point(decode_seq(seq[0], seq[1], seq[2], seq[3], held_len));
      held_cnt = 2'd0;
      held_len = 3'd0;
    end else begin
      held[cnt] = b;
      held_cnt  = held_cnt + 2'd1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: predict on input acceptance, check on output acceptance
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : scoreboard
    utf16_byte_t due;
    int unsigned k;
    if (rst_ni && in_valid_i && in_stall_o) backpressure_cycles++;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      transcode_word(data_byte_i, last_of_buffer_i);
      // hand-typed rows replace the shadow result, the shadow state still advances
      if (offer_typed) begin
        utf16_now.delete();
        for (k = 0; k < offer_n; k++) utf16_now.push_back(offer_e[47 - 8*k -: 8]);
      end
      for (k = 0; k < utf16_now.size(); k++) begin
        due.ub = utf16_now[k];
        due.lr = (k == utf16_now.size() - 1);
        utf16_due.push_back(due);
      end
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      bytes_out++;
      if (utf16_due.size() == 0) begin
        $error("out_byte %02h arrived with nothing due", out_byte_o);
        mismatches++;
      end else begin
        due = utf16_due.pop_front();
        if (out_byte_o !== due.ub) begin
          $error("out_byte: expected %02h, got %02h", due.ub, out_byte_o);
          mismatches++;
        end
        if (last_of_run_o !== due.lr) begin
          $error("last_of_run: expected %0b, got %0b", due.lr, last_of_run_o);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern of its own, plus one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : receiver
    stall_mode_e mode;
    int unsigned seg;
    int unsigned n;
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      seg  = $urandom_range(8, 60);
      for (n = 0; n < seg; n++) begin
        @(negedge clk_i);
        if (hold_req && !hold_done) begin
          // block the output long enough for the input side to back up
          out_stall_i <= 1'b1;
          repeat (HoldCycles) @(negedge clk_i);
          hold_done = 1'b1;
        end
        case (mode)
          StallNone:       out_stall_i <= 1'b0;
          StallHalf:       out_stall_i <= 1'($urandom_range(0, 1));
          StallEveryThird: out_stall_i <= (n % 3 == 2);
          default:         out_stall_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender and configuration tasks
  // ---------------------------------------------------------------------------

  // offer one word, holding it until accepted; gaps come between bursts
  task automatic send_word(logic [7:0] b, logic last, logic typed, logic [2:0] n,
                           logic [47:0] e);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    data_byte_i      <= b;
    last_of_buffer_i <= last;
    offer_typed = typed;
    offer_n     = n;
    offer_e     = e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  // mostly well-formed characters with random content, some strays, some cut short
  task automatic send_random_buffer();
    logic [7:0]  seq_q [$];
    logic [7:0]  lead;
    int unsigned n_chars;
    int unsigned c;
    int unsigned sel;
    int unsigned len;
    int unsigned keep;
    n_chars = $urandom_range(1, 8);
    for (c = 0; c < n_chars; c++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        seq_q.push_back({1'b0, 7'($urandom)});
      end else if (sel < 90) begin
        len = (sel < 50) ? 2 : (sel < 70) ? 3 : 4;
        case (len)
          2:       lead = {3'b110, 5'($urandom)};
          3:       lead = {4'b1110, 4'($urandom)};
          default: lead = {5'b11110, 3'($urandom)};
        endcase
        keep = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 2) : len - 1;
        seq_q.push_back(lead);
        // continuations go unchecked, so now and then any byte stands in for one
        repeat (keep) seq_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                                  : {2'b10, 6'($urandom)});
      end else begin
        seq_q.push_back($urandom_range(0, 1) ? {2'b10, 6'($urandom)}
                                             : {5'b11111, 3'($urandom)});
      end
    end
    for (c = 0; c < seq_q.size(); c++)
      send_word(seq_q[c], (c == seq_q.size() - 1), 1'b0, 3'd0, 48'd0);
  endtask

  // stop offering and wait for every due byte, plus the block's internal latency
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (utf16_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_xfer(logic wr, logic [CfgAddrW-1:0] addr, logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    if (wr && addr[2] == CfgIdxBigEndian) big_endian_cfg = wdata[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_byte_order();
    logic [31:0] rd;
    apb_xfer(ApbRead, AddrBigEndian, 32'd0, rd);
    if (rd[0] !== big_endian_cfg) begin
      $error("big_endian_order: expected %0b, got %0b", big_endian_cfg, rd[0]);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [31:0] rd;
    logic        order;
    int unsigned ph;
    int unsigned r;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    data_byte_i      = 8'h00;
    last_of_buffer_i = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = 32'd0;
    offer_typed      = 1'b0;
    offer_n          = 3'd0;
    offer_e          = 48'd0;
    big_endian_cfg   = 1'b0;
    held_cnt         = 2'd0;
    held_len         = 3'd0;
    buf_start        = 1'b1;
    for (r = 0; r < 3; r++) held[r] = 8'h00;
    words_sent          = 0;
    bytes_out           = 0;
    backpressure_cycles = 0;
    mismatches          = 0;
    burst_left          = 0;
    hold_req            = 1'b0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // little-endian out of reset
    check_byte_order();

    for (r = 0; r < DirRows; r++)
      send_word(stim_tab[r].b, stim_tab[r].last, stim_tab[r].typed, stim_tab[r].n,
                stim_tab[r].e);

    // random phases, byte order changed only while the block is drained
    for (ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0:       order = 1'b1;
        1:       order = 1'b0;
        2:       order = 1'($urandom_range(0, 1));
        default: order = 1'b1;
      endcase
      apb_xfer(ApbWrite, AddrBigEndian, {31'd0, order}, rd);
      // a write to an index with no register must leave the byte order alone
      if (ph == 2) apb_xfer(ApbWrite, AddrUnused, {31'd0, ~order}, rd);
      check_byte_order();
      if (ph == 0) begin
        // long gapless burst against the receiver hold-off
        hold_req   = 1'b1;
        burst_left = 40;
      end
      while (words_sent < DirRows + (ph + 1) * 86) send_random_buffer();
    end

    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("covered %0d utf-8 words in, %0d utf-16 bytes out, both byte orders",
             words_sent, bytes_out);
    $display("input held back for %0d cycles under output stalls", backpressure_cycles);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // far beyond the slowest legal run: six bytes per word under heavy stalls
  initial begin : watchdog
    #3_600_000;
    $display("timeout with %0d bytes still due", utf16_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
